/* rtl/pfc_pkg.sv */
// ----------------------------------------------------------------------------
// pfc_pkg
// shared codes and field widths of the partitioned convolver
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int ACTION_W   = 2;
    localparam int IR_INDEX_W = 12;
    localparam int CFG_W      = 5;

    localparam logic [ACTION_W-1:0] ACT_SAMPLE   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_IR_WRITE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESTART  = 2'd2;

endpackage

/* rtl/pfc_if.sv */
// ----------------------------------------------------------------------------
// pfc_in_if / pfc_out_if
// valid/ready channels of the partitioned convolver
// ----------------------------------------------------------------------------
interface pfc_in_if #(
    parameter int SAMPLE_BITS = 24
);
    import pfc_pkg::*;
    logic                           valid;
    logic                           ready;
    logic        [ACTION_W-1:0]     action;
    logic signed [SAMPLE_BITS-1:0]  sample;
    logic        [IR_INDEX_W-1:0]   ir_index;

    modport source (output valid, action, sample, ir_index, input ready);
    modport sink   (input valid, action, sample, ir_index, output ready);
endinterface

interface pfc_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_BITS-1:0]  out_sample;

    modport source (output valid, out_sample, input ready);
    modport sink   (input valid, out_sample, output ready);
endinterface

/* rtl/partitioned_fft_convolver.sv */
// ----------------------------------------------------------------------------
// partitioned_fft_convolver
// uniformly partitioned block convolver, one shared multiply-accumulate unit
// ----------------------------------------------------------------------------
// channel  | dir | payload                          | note
// req      | in  | action, sample, ir_index         | one beat per command
// rsp      | out | out_sample                       | one beat per audio sample
// cfg      | in  | cfg_we, cfg_wdata                | partition_count, no read-back
//
// with a nonzero count, an audio sample passes the latch state before its output
// beat; an ir write that closes a partition adds a copy of the staging buffer
// every BLOCK_SIZE-th sample adds a window copy, a pass of the single multiplier
// over all BLOCK_SIZE*BLOCK_SIZE*parts terms and a drain of its pipeline
// reset and restart run a clearing pass over the delay, history and output memories
// req is not ready while a beat waits on rsp or the sequencer is busy
// ----------------------------------------------------------------------------
module partitioned_fft_convolver #(
    parameter int BLOCK_SIZE     = 256,
    parameter int MAX_PARTITIONS = 16,
    parameter int SAMPLE_BITS    = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [pfc_pkg::CFG_W-1:0]   cfg_wdata,
    pfc_in_if.sink                      req,
    pfc_out_if.source                   rsp
);
    import pfc_pkg::*;

    // geometry
    localparam int SB     = SAMPLE_BITS;
    localparam int BW     = $clog2(BLOCK_SIZE);
    localparam int WIN    = 2 * BLOCK_SIZE;
    localparam int WB     = BW + 1;
    localparam int SLOT_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int PW     = $clog2(MAX_PARTITIONS + 1);
    localparam int IRD    = (1 << SLOT_W) * BLOCK_SIZE;
    localparam int DD     = (1 << SLOT_W) * WIN;
    localparam int AW     = $clog2(DD);
    localparam int IRA    = SLOT_W + BW;
    localparam int ACC_RAW = 2 * SB + $clog2(MAX_PARTITIONS * BLOCK_SIZE) + 1;
    localparam int ACC_W  = (ACC_RAW > 64) ? 64 : ACC_RAW;

    localparam logic signed [ACC_W-1:0] SMAX = {{(ACC_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;
    localparam logic signed [ACC_W-1:0] RHALF = ACC_W'(1) << (SB - 2);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_LATCH, S_IRCOPY, S_COPY, S_COPY_END, S_MAC, S_MAC_END
    } state_t;

    // memories
    logic signed [SB-1:0] stage_mem [BLOCK_SIZE];
    logic signed [SB-1:0] ir_mem    [IRD];
    logic signed [SB-1:0] dly_mem   [DD];
    logic signed [SB-1:0] hist_mem  [WIN];
    logic signed [SB-1:0] outb_mem  [BLOCK_SIZE];

    // registered read data
    logic signed [SB-1:0] stage_rd, ir_rd, dly_rd, hist_rd, outb_rd;

    // control state
    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     cnt_reg, cnt_next;
    logic [AW-1:0]        ctr_reg, ctr_next;
    logic [BW-1:0]        pos_reg, pos_next;
    logic [SLOT_W-1:0]    ds_reg, ds_next;
    logic [SLOT_W-1:0]    cur_slot_reg, cur_slot_next;
    logic [SLOT_W-1:0]    part_reg, part_next;
    logic                 out_vld_reg, out_vld_next;
    logic signed [SB-1:0] out_data_reg, out_data_next;
    logic                 cp_vld_reg, cp_vld_next;
    logic                 ic_vld_reg, ic_vld_next;
    logic [WB-1:0]        cp_idx_reg, cp_idx_next;

    // mac sequencer and pipeline
    logic [BW-1:0]        n_reg, n_next, k_reg, k_next;
    logic [SLOT_W-1:0]    p_reg, p_next;
    logic                 s1_vld_reg, s1_vld_next, s1_last_reg, s1_last_next;
    logic [BW-1:0]        s1_n_reg, s1_n_next;
    logic                 s2_vld_reg, s2_vld_next, s2_last_reg, s2_last_next;
    logic [BW-1:0]        s2_n_reg, s2_n_next;
    logic signed [2*SB-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next, sum_reg, sum_next;
    logic                 s3_vld_reg, s3_vld_next;
    logic [BW-1:0]        s3_n_reg, s3_n_next;

    // memory ports
    logic                 stage_we, ir_we, dly_we, hist_we, outb_we;
    logic [BW-1:0]        stage_wa, stage_ra, outb_wa, outb_ra;
    logic [IRA-1:0]       ir_wa, ir_ra;
    logic [AW-1:0]        dly_wa, dly_ra;
    logic [WB-1:0]        hist_wa, hist_ra;
    logic signed [SB-1:0] stage_wd, ir_wd, dly_wd, hist_wd, outb_wd;

    // combinational helpers
    logic                 accept;
    logic [PW-1:0]        parts;
    logic [SLOT_W:0]      slot_sum, slot_rd, slot_inc;
    logic [SLOT_W-1:0]    slot_w;
    logic [SLOT_W-1:0]    hp;
    logic [WB-1:0]        widx;
    logic                 k_last, p_last;
    logic signed [ACC_W-1:0] rnd_t, rnd_q;
    logic signed [SB-1:0] rnd_sat;

    assign accept     = req.valid && req.ready;
    assign req.ready  = (state_reg == S_IDLE) && !out_vld_reg;
    assign rsp.valid  = out_vld_reg;
    assign rsp.out_sample = out_data_reg;

    // a count beyond the delay line acts as the full line
    assign parts = (32'(cnt_reg) > MAX_PARTITIONS) ? PW'(MAX_PARTITIONS) : PW'(cnt_reg);

    // delay slot of the term being issued, read modulo the count
    assign slot_sum = (SLOT_W+1)'(ds_reg) + (SLOT_W+1)'(p_reg);
    assign slot_rd  = (32'(slot_sum) >= 32'(parts)) ? slot_sum - (SLOT_W+1)'(parts)
                                                    : slot_sum;
    assign hp       = SLOT_W'(parts - PW'(1) - PW'(p_reg));
    assign widx     = WB'(BLOCK_SIZE) + WB'(n_reg) - WB'(k_reg);
    assign k_last   = (k_reg == BW'(BLOCK_SIZE - 1));
    assign p_last   = (32'(p_reg) == 32'(parts) - 1);

    // slot taken by the window at the end of a block, and the one after it
    assign slot_w   = (32'(ds_reg) >= 32'(parts)) ? '0 : ds_reg;
    assign slot_inc = (SLOT_W+1)'(slot_w) + (SLOT_W+1)'(1);

    // round half up, then saturate
    assign rnd_t   = sum_reg + RHALF;
    assign rnd_q   = rnd_t >>> (SB - 1);
    assign rnd_sat = (rnd_q > SMAX) ? SB'(SMAX) : (rnd_q < SMIN) ? SB'(SMIN) : SB'(rnd_q);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cfg_we ? cfg_wdata : cnt_reg;
        ctr_next      = ctr_reg;
        pos_next      = pos_reg;
        ds_next       = ds_reg;
        cur_slot_next = cur_slot_reg;
        part_next     = part_reg;
        out_vld_next  = out_vld_reg && !rsp.ready;
        out_data_next = out_data_reg;
        cp_vld_next   = 1'b0;
        ic_vld_next   = 1'b0;
        cp_idx_next   = ctr_reg[WB-1:0];
        n_next        = n_reg;
        p_next        = p_reg;
        k_next        = k_reg;
        s1_vld_next   = 1'b0;
        s1_last_next  = k_last && p_last;
        s1_n_next     = n_reg;

        // default read addresses
        stage_ra = ctr_reg[BW-1:0];
        hist_ra  = ctr_reg[WB-1:0];
        outb_ra  = pos_reg;
        ir_ra    = {hp, k_reg};
        dly_ra   = {slot_rd[SLOT_W-1:0], widx};

        // write ports
        stage_we = 1'b0;
        stage_wa = req.ir_index[BW-1:0];
        stage_wd = req.sample;
        ir_we    = ic_vld_reg;
        ir_wa    = {part_reg, cp_idx_reg[BW-1:0]};
        ir_wd    = stage_rd;
        dly_we   = cp_vld_reg;
        dly_wa   = {cur_slot_reg, cp_idx_reg};
        dly_wd   = hist_rd;
        // history shift: upper half moves down while the window is copied
        hist_we  = cp_vld_reg && cp_idx_reg[BW];
        hist_wa  = {1'b0, cp_idx_reg[BW-1:0]};
        hist_wd  = hist_rd;
        outb_we  = s3_vld_reg;
        outb_wa  = s3_n_reg;
        outb_wd  = rnd_sat;

        case (state_reg)
            S_CLEAR:
            begin
                dly_we  = 1'b1;
                dly_wa  = ctr_reg;
                dly_wd  = '0;
                hist_we = (32'(ctr_reg) < WIN);
                hist_wa = ctr_reg[WB-1:0];
                hist_wd = '0;
                outb_we = (32'(ctr_reg) < BLOCK_SIZE);
                outb_wa = ctr_reg[BW-1:0];
                outb_wd = '0;
                ctr_next = ctr_reg + AW'(1);
                if (ctr_reg == AW'(DD - 1))
                begin
                    state_next = S_IDLE;
                    pos_next   = '0;
                    ds_next    = '0;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.action)
                        ACT_IR_WRITE:
                        begin
                            stage_we = 1'b1;
                            if (req.ir_index[BW-1:0] == BW'(BLOCK_SIZE - 1)
                                && 32'(req.ir_index >> BW) < MAX_PARTITIONS)
                            begin
                                part_next  = SLOT_W'(req.ir_index >> BW);
                                ctr_next   = '0;
                                state_next = S_IRCOPY;
                            end
                        end
                        ACT_RESTART:
                        begin
                            ctr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        ACT_SAMPLE:
                        begin
                            if (parts == '0)
                            begin
                                out_vld_next  = 1'b1;
                                out_data_next = req.sample;
                            end
                            else
                            begin
                                hist_we    = 1'b1;
                                hist_wa    = {1'b1, pos_reg};
                                hist_wd    = req.sample;
                                state_next = S_LATCH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LATCH:
            begin
                out_vld_next  = 1'b1;
                out_data_next = outb_rd;
                pos_next      = pos_reg + BW'(1);
                state_next    = S_IDLE;
                if (pos_reg == BW'(BLOCK_SIZE - 1))
                begin
                    cur_slot_next = slot_w;
                    ds_next       = (32'(slot_inc) >= 32'(parts)) ? '0 : slot_inc[SLOT_W-1:0];
                    ctr_next      = '0;
                    state_next    = S_COPY;
                end
            end
            S_IRCOPY:
            begin
                ic_vld_next = 1'b1;
                ctr_next    = ctr_reg + AW'(1);
                if (ctr_reg[BW-1:0] == BW'(BLOCK_SIZE - 1))
                    state_next = S_IDLE;
            end
            S_COPY:
            begin
                cp_vld_next = 1'b1;
                ctr_next    = ctr_reg + AW'(1);
                if (ctr_reg[WB-1:0] == WB'(WIN - 1))
                    state_next = S_COPY_END;
            end
            S_COPY_END:
            begin
                n_next     = '0;
                p_next     = '0;
                k_next     = '0;
                state_next = S_MAC;
            end
            S_MAC:
            begin
                s1_vld_next = 1'b1;
                k_next      = k_reg + BW'(1);
                if (k_last)
                begin
                    p_next = p_reg + SLOT_W'(1);
                    if (p_last)
                    begin
                        p_next = '0;
                        n_next = n_reg + BW'(1);
                        if (n_reg == BW'(BLOCK_SIZE - 1))
                        begin
                            ctr_next   = '0;
                            state_next = S_MAC_END;
                        end
                    end
                end
            end
            S_MAC_END:
            begin
                // drain the multiply-accumulate pipeline
                ctr_next = ctr_reg + AW'(1);
                if (ctr_reg[1:0] == 2'd3)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // shared multiply-accumulate pipeline
        s2_vld_next  = s1_vld_reg;
        s2_last_next = s1_last_reg;
        s2_n_next    = s1_n_reg;
        prod_next    = ir_rd * dly_rd;
        s3_vld_next  = 1'b0;
        s3_n_next    = s2_n_reg;
        sum_next     = sum_reg;
        acc_next     = acc_reg;
        if (s2_vld_reg)
        begin
            if (s2_last_reg)
            begin
                sum_next    = acc_reg + ACC_W'(prod_reg);
                acc_next    = '0;
                s3_vld_next = 1'b1;
            end
            else
            begin
                acc_next = acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            cnt_reg      <= '0;
            ctr_reg      <= '0;
            pos_reg      <= '0;
            ds_reg       <= '0;
            cur_slot_reg <= '0;
            part_reg     <= '0;
            out_vld_reg  <= 1'b0;
            cp_vld_reg   <= 1'b0;
            ic_vld_reg   <= 1'b0;
            n_reg        <= '0;
            p_reg        <= '0;
            k_reg        <= '0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s3_vld_reg   <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            ctr_reg      <= ctr_next;
            pos_reg      <= pos_next;
            ds_reg       <= ds_next;
            cur_slot_reg <= cur_slot_next;
            part_reg     <= part_next;
            out_vld_reg  <= out_vld_next;
            cp_vld_reg   <= cp_vld_next;
            ic_vld_reg   <= ic_vld_next;
            n_reg        <= n_next;
            p_reg        <= p_next;
            k_reg        <= k_next;
            s1_vld_reg   <= s1_vld_next;
            s2_vld_reg   <= s2_vld_next;
            s3_vld_reg   <= s3_vld_next;
            acc_reg      <= acc_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        cp_idx_reg   <= cp_idx_next;
        s1_last_reg  <= s1_last_next;
        s1_n_reg     <= s1_n_next;
        s2_last_reg  <= s2_last_next;
        s2_n_reg     <= s2_n_next;
        prod_reg     <= prod_next;
        sum_reg      <= sum_next;
        s3_n_reg     <= s3_n_next;
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (stage_we)
            stage_mem[stage_wa] <= stage_wd;
        stage_rd <= stage_mem[stage_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ir_we)
            ir_mem[ir_wa] <= ir_wd;
        ir_rd <= ir_mem[ir_ra];
    end

    always_ff @(posedge clk)
    begin
        if (dly_we)
            dly_mem[dly_wa] <= dly_wd;
        dly_rd <= dly_mem[dly_ra];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_wa] <= hist_wd;
        hist_rd <= hist_mem[hist_ra];
    end

    always_ff @(posedge clk)
    begin
        if (outb_we)
            outb_mem[outb_wa] <= outb_wd;
        outb_rd <= outb_mem[outb_ra];
    end

    // checks
    a_sample_latch: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.action == ACT_SAMPLE && parts != '0) |=> state_reg == S_LATCH)
        else $error("audio beat did not reach latch");

    a_outb_write_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
        s3_vld_reg |-> (state_reg == S_MAC || state_reg == S_MAC_END))
        else $error("output block written outside block computation");

    a_copy_origin: assert property (@(posedge clk) disable iff (!rst_n)
        cp_vld_reg |-> $past(state_reg == S_COPY))
        else $error("window copy write without copy phase");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC || state_reg == S_CLEAR) |-> !accept)
        else $error("beat taken while sequencer busy");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the partitioned convolver: a queue-fed driver,
// a checking monitor and an in-bench block convolution predictor
// ----------------------------------------------------------------------------
module tb;
    import pfc_pkg::*;

    localparam int BLK   = 256;
    localparam int WIN   = 2 * BLK;
    localparam int PARTS = 16;
    localparam int SB    = 24;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int unsigned WATCHDOG_LIMIT = 4000000;
    localparam logic signed [SB-1:0] SMAX = 24'sh7fffff;
    localparam logic signed [SB-1:0] SMIN = -24'sh800000;

    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic signed [SB-1:0]  sample;
        logic [IR_INDEX_W-1:0] ir_index;
    } cmd_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    pfc_in_if  #(.SAMPLE_BITS(SB)) req ();
    pfc_out_if #(.SAMPLE_BITS(SB)) rsp ();

    partitioned_fft_convolver #(
        .BLOCK_SIZE    (BLK),
        .MAX_PARTITIONS(PARTS),
        .SAMPLE_BITS   (SB)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .req      (req),
        .rsp      (rsp)
    );

    // 4 ns period
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------------
    // convolution predictor state
    // ------------------------------------------------------------------------
    logic signed [SB-1:0] staging     [BLK];
    logic signed [SB-1:0] ir_taps     [PARTS][BLK];
    logic signed [SB-1:0] window_line [PARTS][WIN];
    logic signed [SB-1:0] history     [WIN];
    logic signed [SB-1:0] next_block  [BLK];
    int unsigned          fill_pos;
    int unsigned          window_slot;
    logic [CFG_W-1:0]     part_count;

    cmd_t                 pending_cmds [$];
    logic signed [SB-1:0] expected_out [$];

    int  send_idle_pct;
    int  recv_stall_pct;
    int  error_count;

    // wipe everything that a restart clears
    task automatic clear_stream();
        foreach (window_line[p, n]) window_line[p][n] = '0;
        foreach (history[n]) history[n] = '0;
        foreach (next_block[n]) next_block[n] = '0;
        fill_pos    = BLK;
        window_slot = 0;
    endtask

    // round half up, then clamp to the sample range
    function automatic logic signed [SB-1:0] round_clamp(longint acc);
        longint q;
        q = (acc + (longint'(1) <<< (SB - 2))) >>> (SB - 1);
        if (q > longint'(SMAX)) q = SMAX;
        if (q < longint'(SMIN)) q = SMIN;
        return q[SB-1:0];
    endfunction

    // store the window, then build the next output block by direct convolution
    task automatic close_block(int unsigned parts);
        longint acc;
        int unsigned slot;
        if (window_slot >= parts) window_slot = 0;
        for (int n = 0; n < WIN; n++) window_line[window_slot][n] = history[n];
        window_slot++;
        if (window_slot >= parts) window_slot = 0;
        for (int n = 0; n < BLK; n++)
        begin
            acc = 0;
            for (int p = 0; p < parts; p++)
            begin
                slot = (window_slot + p) % parts;
                for (int k = 0; k < BLK; k++)
                    acc += longint'(ir_taps[parts-1-p][k])
                         * longint'(window_line[slot][BLK+n-k]);
            end
            next_block[n] = round_clamp(acc);
        end
        for (int n = 0; n < BLK; n++) history[n] = history[BLK+n];
    endtask

    task automatic predict_convolver(cmd_t c);
        int unsigned parts;
        int unsigned off;
        int unsigned part;
        parts = (part_count > PARTS) ? PARTS : part_count;
        off   = c.ir_index % BLK;
        part  = c.ir_index / BLK;
        case (c.action)
            ACT_IR_WRITE:
            begin
                staging[off] = c.sample;
                if (off == BLK - 1 && part < PARTS)
                    for (int k = 0; k < BLK; k++) ir_taps[part][k] = staging[k];
            end
            ACT_RESTART:
                clear_stream();
            ACT_SAMPLE:
            begin
                if (parts == 0)
                    expected_out = {expected_out, c.sample};
                else
                begin
                    if (fill_pos < BLK || fill_pos >= WIN) fill_pos = BLK;
                    history[fill_pos] = c.sample;
                    expected_out = {expected_out, next_block[fill_pos-BLK]};
                    fill_pos++;
                    if (fill_pos == WIN)
                    begin
                        fill_pos = BLK;
                        close_block(parts);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // driver: takes the head of the pending queue, holds it until accepted
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid    <= 1'b0;
            req.action   <= ACT_SAMPLE;
            req.sample   <= '0;
            req.ir_index <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                predict_convolver(pending_cmds.pop_front());
            end
            // a new beat may only be presented once the previous one is gone
            if (!req.valid || req.ready)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req.valid    <= 1'b1;
                    req.action   <= pending_cmds[0].action;
                    req.sample   <= pending_cmds[0].sample;
                    req.ir_index <= pending_cmds[0].ir_index;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random back-pressure, compare each output beat in order
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
            if (rsp.valid && rsp.ready)
            begin
                if (expected_out.size() == 0)
                begin
                    $error("out_sample: no beat expected, actual %0d", rsp.out_sample);
                    error_count++;
                end
                else if (rsp.out_sample !== expected_out[0])
                begin
                    $error("out_sample: expected %0d, actual %0d",
                           expected_out[0], rsp.out_sample);
                    error_count++;
                    void'(expected_out.pop_front());
                end
                else
                    void'(expected_out.pop_front());
            end
        end
    end

    // watchdog on cycles without any accepted beat
    int unsigned quiet_cycles;
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_cmd(logic [ACTION_W-1:0] a, logic signed [SB-1:0] s,
                            logic [IR_INDEX_W-1:0] idx);
        cmd_t c;
        c.action   = a;
        c.sample   = s;
        c.ir_index = idx;
        pending_cmds = {pending_cmds, c};
    endtask

    // full scale, extremes and quiet values mixed
    function automatic logic signed [SB-1:0] pick_sample();
        int r;
        r = $urandom_range(15);
        if (r == 0) return SMAX;
        if (r == 1) return SMIN;
        if (r < 6) return $signed(24'($urandom_range(4095))) - 24'sd2048;
        return SB'($urandom);
    endfunction

    // drain both queues, then wait for the sequencer to report idle
    task automatic settle();
        int idle_run;
        while (pending_cmds.size() > 0 || expected_out.size() > 0) @(negedge clk);
        repeat (8) @(negedge clk);
        idle_run = 0;
        while (idle_run < 4)
        begin
            @(negedge clk);
            idle_run = req.ready ? idle_run + 1 : 0;
        end
    endtask

    task automatic write_parts(logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        part_count = v;
        @(negedge clk);
    endtask

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
        endcase
    endtask

    // audio stream with ir updates, ignored codes and rare restarts mixed in
    task automatic stream_phase(int n_audio);
        int r;
        for (int i = 0; i < n_audio; i++)
        begin
            r = $urandom_range(99);
            if (r < 5)
                push_cmd(ACT_IR_WRITE, pick_sample(), IR_INDEX_W'($urandom_range(4095)));
            else if (r < 7)
                push_cmd(ACT_UNUSED, SB'($urandom), IR_INDEX_W'($urandom));
            else if (r == 7 && $urandom_range(3) == 0)
                push_cmd(ACT_RESTART, SB'($urandom), IR_INDEX_W'($urandom));
            push_cmd(ACT_SAMPLE, pick_sample(), IR_INDEX_W'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence of phases
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        error_count = 0;
        part_count  = '0;
        foreach (staging[k]) staging[k] = '0;
        foreach (ir_taps[p, k]) ir_taps[p][k] = '0;
        clear_stream();
        set_idling(0);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // bypass: extremes pass straight through, odd codes ignored
        settle();
        write_parts('0);
        push_cmd(ACT_SAMPLE, SMAX, '0);
        push_cmd(ACT_SAMPLE, SMIN, '1);
        push_cmd(ACT_SAMPLE, '0, '0);
        push_cmd(ACT_SAMPLE, -24'sd1, '0);
        push_cmd(ACT_SAMPLE, 24'sd1, '0);
        push_cmd(ACT_UNUSED, SMAX, '1);
        push_cmd(ACT_RESTART, SMIN, '1);
        push_cmd(ACT_SAMPLE, 24'sh555555, 12'haaa);
        push_cmd(ACT_SAMPLE, 24'shaaaaaa, 12'h555);
        settle();

        // load partition 0 in full, then commit every other partition from
        // the staging buffer with a fresh last tap
        for (int k = 0; k < BLK; k++)
            push_cmd(ACT_IR_WRITE, (k < 4) ? SMAX : pick_sample(), IR_INDEX_W'(k));
        for (int p = 1; p < PARTS; p++)
        begin
            push_cmd(ACT_IR_WRITE, pick_sample(),
                     IR_INDEX_W'(p * BLK + $urandom_range(BLK - 2)));
            push_cmd(ACT_IR_WRITE, (p == 2) ? SMIN : pick_sample(),
                     IR_INDEX_W'(p * BLK + BLK - 1));
        end
        settle();

        // small partition counts, changed mid-block; the block ends in the
        // second and the fourth phase; every settle holds the sender until
        // all results are in
        write_parts(5'd2);
        set_idling(0);
        stream_phase(130);
        settle();

        write_parts(5'd3);
        set_idling(1);
        stream_phase(130);
        settle();

        write_parts(5'd2);
        set_idling(2);
        stream_phase(130);
        settle();

        // shrinking the count leaves the delay slot out of range
        write_parts(5'd1);
        set_idling(3);
        stream_phase(130);
        settle();

        // largest count, kept short of a block end
        write_parts(5'd31);
        set_idling(0);
        push_cmd(ACT_RESTART, '0, '0);
        stream_phase(20);
        settle();

        write_parts('0);
        set_idling(3);
        stream_phase(20);
        settle();

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
